FILE: src/pea_pkg.sv
// Package for the pointer event aggregator: payload structs, event and
// button codes, register indexes and divider sizing.
// Depends on nothing; the core and the testbench import it.
package pea_pkg;

   // Event classes carried in event_type.
   localparam logic [15:0] EvSync = 16'h0000;
   localparam logic [15:0] EvKey  = 16'h0001;
   localparam logic [15:0] EvRel  = 16'h0002;
   localparam logic [15:0] EvAbs  = 16'h0003;

   // Axis and button codes carried in event_code.
   localparam logic [15:0] CodeX      = 16'h0000;
   localparam logic [15:0] CodeY      = 16'h0001;
   localparam logic [15:0] CodeWheel  = 16'h0008;
   localparam logic [15:0] CodeLeft   = 16'h0110;
   localparam logic [15:0] CodeRight  = 16'h0111;
   localparam logic [15:0] CodeMiddle = 16'h0112;

   // Button bit masks.
   localparam logic [2:0] BtnLeft   = 3'b001;
   localparam logic [2:0] BtnRight  = 3'b010;
   localparam logic [2:0] BtnMiddle = 3'b100;

   // Register file layout: four 31-bit registers at byte addresses 0, 4, 8, 12.
   localparam int CsrAddrWidth = 4;
   localparam logic [1:0] RegXMin = 2'd0;
   localparam logic [1:0] RegXMax = 2'd1;
   localparam logic [1:0] RegYMin = 2'd2;
   localparam logic [1:0] RegYMax = 2'd3;
   localparam logic [30:0] RangeResetMax = 31'h0000_7fff;

   // The scaled position is a 16-bit quotient, one bit per divider step.
   localparam int DivSteps    = 16;
   localparam int DivCntWidth = $clog2(DivSteps);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CLAMP,
      ST_PREP,
      ST_DIV
   } state_type;

   typedef struct packed {
      logic [15:0]        event_type;
      logic [15:0]        event_code;
      logic signed [31:0] event_value;
   } event_type_s_type;

   typedef struct packed {
      logic [2:0]         button_bits;
      logic signed [15:0] move_x;
      logic signed [15:0] move_y;
      logic signed [7:0]  wheel_delta;
      logic               is_absolute;
   } packet_type;

endpackage

FILE: src/pea_stream_if.sv
// Valid/ready stream interface used for the event and packet channels.
// The payload type is set per instance; depends on nothing else.
interface pea_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: src/pointer_event_aggregator_core.sv
// Top level of the pointer event aggregator: event decode, accumulators,
// the serial scaling divider and the packet output stage.
// Depends on pea_pkg and pea_stream_if.

// The block takes input events (type, code, signed value) on req_chan and
// sends pointer packets on rsp_chan. Key, relative and sync events, and
// absolute events on unknown codes, are handled in the idle state, and the
// block is ready again in the next cycle unless the skid register filled.
// An absolute X or Y event keeps it busy: the clamp state clamps the raw
// value to the configured range, the prep state forms (value-min)*65535,
// and in the divide state one shared 32-bit subtractor produces one quotient
// bit per cycle of the division by (max-min). When max is not above min the
// raw value's low 16 bits are taken in the clamp state and the division is
// skipped. A sync event produces one packet when anything changed since the
// last packet or the wheel sum is nonzero. Packets go to an output register
// backed by one skid register, so a finished packet may wait on rsp_chan
// while new events are taken; outside the scaling states, input stalls only
// while both hold a packet. Range registers are written through the
// APB-style port and must only be written while the block is idle.
module pointer_event_aggregator_core (
   input  logic                            clock,
   input  logic                            reset,
   pea_stream_if.sink                      req_chan,
   pea_stream_if.source                    rsp_chan,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [pea_pkg::CsrAddrWidth-1:0] paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);
   import pea_pkg::*;

   // Range registers.
   logic [30:0] x_min_ff, x_max_ff, y_min_ff, y_max_ff;
   logic [1:0]  csr_index;
   logic        csr_write;

   // Sequencer and divider state.
   state_type               state_ff, state_in;
   logic [31:0]             raw_ff, raw_in;
   logic                    axis_ff, axis_in;
   logic [30:0]             diff_ff, diff_in;
   logic [30:0]             den_ff, den_in;
   logic [30:0]             rem_ff, rem_in;
   logic [DivSteps-1:0]     quo_ff, quo_in;
   logic [DivCntWidth-1:0]  cnt_ff, cnt_in;

   // Architectural pointer state.
   logic [15:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic        abs_seen_ff, abs_seen_in;
   logic [31:0] sum_x_ff, sum_x_in, sum_y_ff, sum_y_in, sum_wheel_ff, sum_wheel_in;
   logic [2:0]  buttons_ff, buttons_in;
   logic        pending_ff, pending_in;

   // Output register and skid register.
   packet_type out_ff, out_in, skid_ff, skid_in;
   logic       out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;

   // Combinational helpers.
   event_type_s_type ev;
   packet_type       pkt;
   logic             req_ready, req_fire, emit, out_take;
   logic [30:0]      axis_lo, axis_hi, clamped;
   logic [46:0]      numer;
   logic [31:0]      shifted;
   logic [32:0]      trial;
   logic             ge;
   logic [2:0]       btn_mask;

   // ------------------------------------------------------------------
   // Configuration port. Writes complete in the access phase; pready is
   // tied high so every access finishes without wait states.
   // ------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_index = paddr[CsrAddrWidth-1:2];
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_min_ff <= '0;
         x_max_ff <= RangeResetMax;
         y_min_ff <= '0;
         y_max_ff <= RangeResetMax;
      end else if (csr_write) begin
         case (csr_index)
            RegXMin: x_min_ff <= pwdata[30:0];
            RegXMax: x_max_ff <= pwdata[30:0];
            RegYMin: y_min_ff <= pwdata[30:0];
            RegYMax: y_max_ff <= pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         RegXMin: prdata = {1'b0, x_min_ff};
         RegXMax: prdata = {1'b0, x_max_ff};
         RegYMin: prdata = {1'b0, y_min_ff};
         RegYMax: prdata = {1'b0, y_max_ff};
         default: prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Datapath pieces shared by the sequencer states.
   // ------------------------------------------------------------------
   assign ev       = req_chan.payload;
   assign req_fire = req_chan.valid && req_ready;
   assign out_take = out_valid_ff && rsp_chan.ready;

   assign axis_lo = axis_ff ? y_min_ff : x_min_ff;
   assign axis_hi = axis_ff ? y_max_ff : x_max_ff;

   // A negative raw value lies below every minimum.
   always_comb begin
      if (raw_ff[31] || (raw_ff[30:0] < axis_lo)) begin
         clamped = axis_lo;
      end else if (raw_ff[30:0] > axis_hi) begin
         clamped = axis_hi;
      end else begin
         clamped = raw_ff[30:0];
      end
   end

   // diff*65535 written as diff*65536 - diff.
   assign numer = {diff_ff, 16'h0000} - {16'h0000, diff_ff};

   // One restoring-division step: the partial remainder stays below the
   // divisor, so after the shift it fits 32 bits and needs one subtract.
   assign shifted = {rem_ff, quo_ff[DivSteps-1]};
   assign trial   = {1'b0, shifted} - {2'b00, den_ff};
   assign ge      = !trial[32];

   always_comb begin
      case (ev.event_code)
         CodeLeft:   btn_mask = BtnLeft;
         CodeRight:  btn_mask = BtnRight;
         CodeMiddle: btn_mask = BtnMiddle;
         default:    btn_mask = 3'b000;
      endcase
   end

   always_comb begin
      pkt.button_bits = buttons_ff;
      pkt.move_x      = abs_seen_ff ? pos_x_ff : sum_x_ff[15:0];
      pkt.move_y      = abs_seen_ff ? pos_y_ff : sum_y_ff[15:0];
      pkt.wheel_delta = sum_wheel_ff[7:0];
      pkt.is_absolute = abs_seen_ff;
   end

   // ------------------------------------------------------------------
   // Sequencer: next state and all register updates.
   // ------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      raw_in       = raw_ff;
      axis_in      = axis_ff;
      diff_in      = diff_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      abs_seen_in  = abs_seen_ff;
      sum_x_in     = sum_x_ff;
      sum_y_in     = sum_y_ff;
      sum_wheel_in = sum_wheel_ff;
      buttons_in   = buttons_ff;
      pending_in   = pending_ff;
      req_ready    = 1'b0;
      emit         = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = !skid_valid_ff;
            if (req_fire) begin
               case (ev.event_type)
                  EvAbs: begin
                     if ((ev.event_code == CodeX) || (ev.event_code == CodeY)) begin
                        raw_in      = ev.event_value;
                        axis_in     = (ev.event_code == CodeY);
                        abs_seen_in = 1'b1;
                        pending_in  = 1'b1;
                        state_in    = ST_CLAMP;
                     end
                  end
                  EvRel: begin
                     if (ev.event_code == CodeX) begin
                        sum_x_in   = sum_x_ff + ev.event_value;
                        pending_in = 1'b1;
                     end else if (ev.event_code == CodeY) begin
                        sum_y_in   = sum_y_ff + ev.event_value;
                        pending_in = 1'b1;
                     end else if (ev.event_code == CodeWheel) begin
                        sum_wheel_in = sum_wheel_ff + ev.event_value;
                        pending_in   = 1'b1;
                     end
                  end
                  EvKey: begin
                     if (btn_mask != 3'b000) begin
                        buttons_in = (ev.event_value != 32'sd0) ? (buttons_ff | btn_mask)
                                                                : (buttons_ff & ~btn_mask);
                        pending_in = 1'b1;
                     end
                  end
                  EvSync: begin
                     if (pending_ff || (sum_wheel_ff != 32'h0000_0000)) begin
                        emit         = 1'b1;
                        sum_x_in     = '0;
                        sum_y_in     = '0;
                        sum_wheel_in = '0;
                        pending_in   = 1'b0;
                     end
                  end
                  default: ;
               endcase
            end
         end

         ST_CLAMP: begin
            if (axis_hi <= axis_lo) begin
               // Max not above min: the raw value passes through unclamped.
               if (axis_ff) begin
                  pos_y_in = raw_ff[15:0];
               end else begin
                  pos_x_in = raw_ff[15:0];
               end
               state_in = ST_IDLE;
            end else begin
               diff_in  = clamped - axis_lo;
               den_in   = axis_hi - axis_lo;
               state_in = ST_PREP;
            end
         end

         ST_PREP: begin
            rem_in   = numer[46:DivSteps];
            quo_in   = numer[DivSteps-1:0];
            cnt_in   = '0;
            state_in = ST_DIV;
         end

         ST_DIV: begin
            rem_in = ge ? trial[30:0] : shifted[30:0];
            quo_in = {quo_ff[DivSteps-2:0], ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DivCntWidth'(DivSteps - 1)) begin
               if (axis_ff) begin
                  pos_y_in = quo_in;
               end else begin
                  pos_x_in = quo_in;
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register plus skid register. Input is held off while the skid
   // register is full, so a new packet always finds a free slot.
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (out_take) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = pkt;
            out_valid_in = emit;
         end
      end else if (emit) begin
         if (out_valid_ff) begin
            skid_in       = pkt;
            skid_valid_in = 1'b1;
         end else begin
            out_in       = pkt;
            out_valid_in = 1'b1;
         end
      end
   end

   assign req_chan.ready   = req_ready;
   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_ff;

   // Control state and pointer state are cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pos_x_ff      <= '0;
         pos_y_ff      <= '0;
         abs_seen_ff   <= 1'b0;
         sum_x_ff      <= '0;
         sum_y_ff      <= '0;
         sum_wheel_ff  <= '0;
         buttons_ff    <= '0;
         pending_ff    <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pos_x_ff      <= pos_x_in;
         pos_y_ff      <= pos_y_in;
         abs_seen_ff   <= abs_seen_in;
         sum_x_ff      <= sum_x_in;
         sum_y_ff      <= sum_y_in;
         sum_wheel_ff  <= sum_wheel_in;
         buttons_ff    <= buttons_in;
         pending_ff    <= pending_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Working registers of the divider and the packet payloads.
   always_ff @(posedge clock) begin
      raw_ff  <= raw_in;
      axis_ff <= axis_in;
      diff_ff <= diff_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      cnt_ff  <= cnt_in;
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------

   // The skid register only fills behind a held output register.
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds a packet while the output is empty");

   // No event is taken while the divider sequence runs.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_chan.ready)
      else $error("input ready while the scaling sequence is busy");

   // The last division step always returns the sequencer to idle.
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DIV) && (cnt_ff == DivCntWidth'(DivSteps - 1))) |=>
      (state_ff == ST_IDLE))
      else $error("divider did not finish after its last step");

   // A sync with nothing to report puts no packet into an empty output stage.
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && (ev.event_type == EvSync) && !pending_ff &&
       (sum_wheel_ff == 32'h0000_0000) && !out_valid_ff) |=> !out_valid_ff)
      else $error("packet produced by an empty sync");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for pointer_event_aggregator_core: random and directed event
// traffic against a built-in packet predictor, with range registers set over the APB port.
// Depends on pea_pkg, pea_stream_if and the core from the block's sources.
`timescale 1ns / 1ps

module testbench;
   import pea_pkg::*;

   // Cycles to wait once no packet is outstanding. An absolute event that is
   // still being scaled yields no packet of its own.
   localparam int DrainCycles = 40;
   // Cycles without any transfer or register access before the run is abandoned.
   localparam int HangLimit = 4000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [CsrAddrWidth-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   pea_stream_if #(.payload_type(event_type_s_type)) req_chan ();
   pea_stream_if #(.payload_type(packet_type)) rsp_chan ();

   pointer_event_aggregator_core DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always #5 clock = ~clock;

   // Predictor state. The range registers mirror what has been written over APB,
   // indexed by the register codes from the package.
   logic [30:0] range_reg [4] = '{31'd0, RangeResetMax, 31'd0, RangeResetMax};
   logic [15:0] pos_x = '0;
   logic [15:0] pos_y = '0;
   bit          abs_mode = 1'b0;
   logic [31:0] rel_x = '0;
   logic [31:0] rel_y = '0;
   logic [31:0] wheel_sum = '0;
   logic [2:0]  held_buttons = '0;
   bit          dirty = 1'b0;

   packet_type  packets_due [$];

   int  errors = 0;
   int  events_done = 0;
   int  packets_checked = 0;
   int  range_writes = 0;
   int  idle_cycles = 0;
   int  stall_left = 0;
   // When set, neither side inserts gaps, so the block sees back-to-back transfers.
   bit  no_idle = 1'b0;

   // Gap length for either side: mostly none or short, now and then long.
   function automatic int pick_pause();
      int r;
      if (no_idle)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 45)
         return 0;
      if (r < 90)
         return $urandom_range(1, 4);
      return $urandom_range(12, 40);
   endfunction

   // Absolute position mapping: clamp into [lo, hi] and stretch that span onto
   // 0..65535 with a truncating divide. An empty or inverted span passes the raw
   // value's low half through without clamping. A negative raw value counts as
   // lying below any minimum.
   function automatic logic [15:0] scale_axis(input logic [31:0] raw, input logic [30:0] lo,
                                             input logic [30:0] hi);
      logic [30:0]     clamped;
      longint unsigned numerator;
      if (hi <= lo)
         return raw[15:0];
      if (raw[31] || raw[30:0] < lo)
         clamped = lo;
      else if (raw[30:0] > hi)
         clamped = hi;
      else
         clamped = raw[30:0];
      numerator = clamped - lo;
      numerator = numerator * 64'd65535;
      return 16'(numerator / (hi - lo));
   endfunction

   // Applies one accepted event to the predictor. A sync with something to report
   // queues the packet the block must send. Returns 0 for events the block ignores.
   task automatic track_event(input event_type_s_type ev, output bit counted);
      logic [2:0]  mask;
      packet_type  pkt;
      counted = 1'b1;
      mask = '0;
      case (ev.event_type)
         EvAbs: begin
            if (ev.event_code == CodeX) begin
               pos_x = scale_axis(ev.event_value, range_reg[RegXMin], range_reg[RegXMax]);
               abs_mode = 1'b1;
               dirty = 1'b1;
            end else if (ev.event_code == CodeY) begin
               pos_y = scale_axis(ev.event_value, range_reg[RegYMin], range_reg[RegYMax]);
               abs_mode = 1'b1;
               dirty = 1'b1;
            end else begin
               counted = 1'b0;
            end
         end
         EvRel: begin
            // Sums wrap at 32 bits, just as the block's accumulators do.
            if (ev.event_code == CodeX) begin
               rel_x = rel_x + ev.event_value;
               dirty = 1'b1;
            end else if (ev.event_code == CodeY) begin
               rel_y = rel_y + ev.event_value;
               dirty = 1'b1;
            end else if (ev.event_code == CodeWheel) begin
               wheel_sum = wheel_sum + ev.event_value;
               dirty = 1'b1;
            end else begin
               counted = 1'b0;
            end
         end
         EvKey: begin
            case (ev.event_code)
               CodeLeft:   mask = BtnLeft;
               CodeRight:  mask = BtnRight;
               CodeMiddle: mask = BtnMiddle;
               default:    counted = 1'b0;
            endcase
            if (counted) begin
               held_buttons = (ev.event_value != 0) ? (held_buttons | mask)
                                                    : (held_buttons & ~mask);
               dirty = 1'b1;
            end
         end
         EvSync: begin
            if (dirty || wheel_sum != 0) begin
               pkt.button_bits = held_buttons;
               // Once any absolute event has been seen, packets carry positions for good.
               pkt.move_x = abs_mode ? pos_x : rel_x[15:0];
               pkt.move_y = abs_mode ? pos_y : rel_y[15:0];
               pkt.wheel_delta = wheel_sum[7:0];
               pkt.is_absolute = abs_mode;
               packets_due.push_back(pkt);
               rel_x = '0;
               rel_y = '0;
               wheel_sum = '0;
               dirty = 1'b0;
            end
         end
         default: counted = 1'b0;
      endcase
   endtask

   // Sends one event: an optional gap first, then valid held until the transfer.
   // Valid is left high afterwards, so a following call with no gap keeps the
   // channel busy without a dead cycle.
   task automatic send_event(input logic [15:0] ev_type, input logic [15:0] ev_code,
                             input logic [31:0] ev_value);
      event_type_s_type item;
      bit               counted;
      int               pause;
      pause = pick_pause();
      if (pause > 0) begin
         req_chan.valid <= 1'b0;
         repeat (pause) @(posedge clock);
      end
      item.event_type = ev_type;
      item.event_code = ev_code;
      item.event_value = ev_value;
      req_chan.valid <= 1'b1;
      req_chan.payload <= item;
      do @(posedge clock); while (!req_chan.ready);
      track_event(item, counted);
      if (counted)
         events_done++;
   endtask

   // Lets the block go quiet: no event offered, every packet received, and enough
   // further cycles for a scaling pass that produces no packet to finish.
   task automatic drain();
      req_chan.valid <= 1'b0;
      while (packets_due.size() != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // One APB write: setup phase, then access until pready, then back to idle.
   task automatic write_range(input logic [1:0] index, input logic [30:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= {1'b0, value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      range_reg[index] = value;
      range_writes++;
      @(posedge clock);
   endtask

   task automatic apply_ranges(input logic [30:0] x_lo, input logic [30:0] x_hi,
                               input logic [30:0] y_lo, input logic [30:0] y_hi);
      drain();
      write_range(RegXMin, x_lo);
      write_range(RegXMax, x_hi);
      write_range(RegYMin, y_lo);
      write_range(RegYMax, y_hi);
   endtask

   // Relative delta: mostly small moves either way, sometimes any 32-bit value.
   function automatic logic [31:0] rand_delta();
      if ($urandom_range(0, 3) == 0)
         return $urandom;
      return $urandom_range(0, 200) - 100;
   endfunction

   // Absolute position aimed at the axis's current range: the bounds, just
   // outside them, inside, or anything at all (negative values included).
   function automatic logic [31:0] rand_position(input logic [15:0] axis);
      logic [31:0] lo;
      logic [31:0] hi;
      lo = {1'b0, (axis == CodeX) ? range_reg[RegXMin] : range_reg[RegYMin]};
      hi = {1'b0, (axis == CodeX) ? range_reg[RegXMax] : range_reg[RegYMax]};
      case ($urandom_range(0, 7))
         0: return lo;
         1: return hi;
         2: return lo - 1;
         3: return hi + 1;
         4: return $urandom;
         default: begin
            if (hi > lo)
               return lo + $urandom_range(0, hi - lo);
            return $urandom_range(0, 65535);
         end
      endcase
   endfunction

   // One well-formed report: a few movement or button events closed by a sync.
   // Now and then a junk event is slipped in or the closing sync is left out.
   task automatic send_frame(input bit with_abs);
      int          moves;
      logic [15:0] code;
      if ($urandom_range(0, 11) == 0)
         no_idle = !no_idle;
      if ($urandom_range(0, 6) == 0)
         send_event(16'($urandom), 16'($urandom), $urandom);
      moves = $urandom_range(1, 4);
      repeat (moves) begin
         case ($urandom_range(0, with_abs ? 4 : 2))
            0, 1: begin
               case ($urandom_range(0, 2))
                  0:       code = CodeX;
                  1:       code = CodeY;
                  default: code = CodeWheel;
               endcase
               send_event(EvRel, code, rand_delta());
            end
            2: begin
               case ($urandom_range(0, 2))
                  0:       code = CodeLeft;
                  1:       code = CodeRight;
                  default: code = CodeMiddle;
               endcase
               send_event(EvKey, code, $urandom_range(0, 1) ? $urandom : 32'd0);
            end
            default: begin
               code = $urandom_range(0, 1) ? CodeX : CodeY;
               send_event(EvAbs, code, rand_position(code));
            end
         endcase
      end
      // The block ignores code and value on a sync, so both carry random bits.
      if ($urandom_range(0, 9) != 0)
         send_event(EvSync, 16'($urandom), $urandom);
   endtask

   // Relative reporting only exists before the first absolute event, so it is
   // tested first. Covers wrap of the sums, every button, and ignored events.
   task automatic test_relative_directed();
      send_event(EvSync, CodeX, 32'd0);             // nothing pending: no packet
      send_event(EvRel, CodeX, 32'h7fff_ffff);
      send_event(EvRel, CodeX, 32'h7fff_ffff);      // sum wraps past the top
      send_event(EvRel, CodeY, 32'h8000_0000);
      send_event(EvRel, CodeWheel, 32'hffff_ffff);
      send_event(EvKey, CodeLeft, 32'd1);
      send_event(EvKey, CodeRight, 32'h8000_0000);
      send_event(EvKey, CodeMiddle, 32'hffff_ffff);
      send_event(EvSync, CodeX, 32'd0);
      send_event(EvKey, CodeLeft, 32'd0);           // release
      send_event(16'hffff, 16'hffff, 32'd0);        // unknown class
      send_event(EvRel, 16'hffff, 32'd5);           // unknown axis
      send_event(EvKey, CodeMiddle + 16'd1, 32'd1); // unknown button
      send_event(EvSync, CodeX, 32'd0);
      send_event(EvSync, CodeX, 32'd0);             // already reported: no packet
   endtask

   task automatic test_relative_random();
      int target;
      target = events_done + 550;
      while (events_done < target)
         send_frame(1'b0);
      no_idle = 1'b0;
   endtask

   // Absolute events at the reset range of 0..32767: bounds, a negative value,
   // a value above the maximum, and the sticky absolute mode.
   task automatic test_absolute_directed();
      send_event(EvAbs, CodeX, 32'd0);
      send_event(EvAbs, CodeY, 32'd32767);
      send_event(EvSync, CodeX, 32'd0);
      send_event(EvAbs, CodeX, 32'h8000_0000);
      send_event(EvAbs, CodeY, 32'h7fff_ffff);
      send_event(EvAbs, CodeWheel, 32'd9);           // no wheel axis for absolute
      send_event(EvRel, CodeX, 32'd7);              // still reports positions
      send_event(EvSync, CodeX, 32'd0);
      send_event(EvAbs, CodeX, 32'd16384);
      send_event(EvSync, CodeX, 32'd0);
   endtask

   // Writes random values to all four range registers and reads each one back.
   task automatic test_register_readback();
      logic [1:0] reg_order [4];
      reg_order = '{RegXMin, RegXMax, RegYMin, RegYMax};
      apply_ranges(31'($urandom), 31'($urandom), 31'($urandom), 31'($urandom));
      foreach (reg_order[i]) begin
         psel <= 1'b1;
         penable <= 1'b0;
         pwrite <= 1'b0;
         paddr <= {reg_order[i], 2'b00};
         @(posedge clock);
         penable <= 1'b1;
         do @(posedge clock); while (!pready);
         if (prdata[30:0] !== range_reg[reg_order[i]]) begin
            $display("%0t: register %0d read back, expected %h, actual %h", $time,
                     reg_order[i], range_reg[reg_order[i]], prdata[30:0]);
            errors++;
         end
         psel <= 1'b0;
         penable <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Random reports under several range settings: full span, top-end empty and
   // inverted spans, the narrowest nonempty span, and random spans.
   task automatic test_range_sweep();
      logic [30:0] a;
      logic [30:0] b;
      int          target;
      for (int setting = 0; setting < 6; setting++) begin
         a = 31'($urandom);
         b = 31'($urandom);
         case (setting)
            0: apply_ranges('0, '1, '0, '1);
            1: apply_ranges('1, '1, '1, '0);
            2: apply_ranges(31'd1000, 31'd1001, 31'd0, 31'd1);
            3: apply_ranges((a < b) ? a : b, (a < b) ? b : a, b % 31'd50000,
                            31'(b % 31'd50000 + $urandom_range(1, 70000)));
            4: apply_ranges(a % 31'd100, 31'(a % 31'd100 + $urandom_range(1, 4000)),
                            (a < b) ? a : b, (a < b) ? b : a);
            default: apply_ranges(a, b, b, a);
         endcase
         target = events_done + 200;
         while (events_done < target)
            send_frame(1'b1);
         no_idle = 1'b0;
      end
   endtask

   // Packet receiver: ready follows random stall patterns, and every packet that
   // transfers is compared field by field with the oldest predicted one.
   function automatic bit field_ok(input string name, input logic [15:0] want,
                                   input logic [15:0] got);
      if (got === want)
         return 1'b1;
      $display("%0t: packet %s mismatch, expected %h, actual %h", $time, name, want, got);
      return 1'b0;
   endfunction

   always @(posedge clock) begin
      packet_type want;
      packet_type got;
      bit         ok;
      if (rsp_chan.valid && rsp_chan.ready) begin
         got = rsp_chan.payload;
         if (packets_due.size() == 0) begin
            $display("%0t: packet with none expected, expected none, actual %h", $time, got);
            errors++;
         end else begin
            want = packets_due.pop_front();
            ok = field_ok("button_bits", 16'(want.button_bits), 16'(got.button_bits));
            ok &= field_ok("move_x", want.move_x, got.move_x);
            ok &= field_ok("move_y", want.move_y, got.move_y);
            ok &= field_ok("wheel_delta", 16'(want.wheel_delta), 16'(got.wheel_delta));
            ok &= field_ok("is_absolute", 16'(want.is_absolute), 16'(got.is_absolute));
            if (!ok)
               errors++;
            packets_checked++;
         end
      end
      if (stall_left > 0) begin
         stall_left--;
      end else begin
         stall_left = pick_pause();
         if (stall_left == 0) begin
            rsp_chan.ready <= 1'b1;
            stall_left = $urandom_range(0, 4);
         end else begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end
      end
   end

   // Watchdog: any transfer or register access counts as progress.
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          (psel && penable))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= HangLimit) begin
         $display("%0t: no progress for %0d cycles", $time, HangLimit);
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_relative_directed();
      test_relative_random();
      test_absolute_directed();
      test_register_readback();
      test_range_sweep();
      drain();

      $display("Covered %0d events in relative and absolute modes, %0d packets checked,",
               events_done, packets_checked);
      $display("with %0d range register writes across eight range settings.", range_writes);
      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
